### rtl/core/mtbs_pkg.sv
// Shared constants, types and helpers for the monotonic table bracket search.
`default_nettype none
package mtbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 11;
  localparam int LOC_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  // Request types carried by in_req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_entry;   // store the request key in the table
    logic start_query;   // latch the key and bounds, read the first entry
    logic capture_first; // keep the first entry, read the last entry
    logic set_dir;       // decide the table direction, issue the first probe
    logic probe;         // judge one probe and narrow the bracket
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;   // the bracket has closed on this probe
  } stat_t;

  // Map a key so that an unsigned compare gives the configured ordering.
  function automatic logic [KEY_WIDTH-1:0] order_key(input logic [KEY_WIDTH-1:0] v,
                                                      input logic is_signed);
    logic [KEY_WIDTH-1:0] res;
    res = v;
    res[KEY_WIDTH-1] = v[KEY_WIDTH-1] ^ is_signed;
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mtbs_ctrl.sv
// Controller state machine that sequences loads and binary-search queries.
`default_nettype none
module mtbs_ctrl
  import mtbs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire logic  req_type,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_DIR   = 4'b0100,
    ST_PROBE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.write_entry = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            state_nxt       = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd.capture_first = 1'b1;
        state_nxt         = ST_DIR;
      end
      ST_DIR: begin
        cmd.set_dir = 1'b1;
        state_nxt   = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.search_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mtbs_dp.sv
// Datapath: key table memory, configuration registers and search bounds.
`default_nettype none
module mtbs_dp
  import mtbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic [ADDR_W-1:0]     entry_index,
  input  wire logic [KEY_WIDTH-1:0]  key,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       out_valid,
  output logic [LOC_W-1:0]           out_location
);

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;

  logic [LEN_W-1:0]     table_length_r;
  logic                 signed_keys_r;

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] first_r;
  logic                 asc_r;
  logic [LEN_W-1:0]     n_r;
  logic [LEN_W-1:0]     low_r, low_nxt;
  logic [LEN_W-1:0]     up_r, up_nxt;
  logic [LEN_W-1:0]     mid_r;
  logic                 out_valid_r;
  logic [LOC_W-1:0]     out_location_r;

  logic [LEN_W-1:0]     n_clamp;
  logic [LEN_W:0]       sum_cur, sum_nxt;
  logic [LEN_W-1:0]     mid_cur, mid_nxt;
  logic [KEY_WIDTH-1:0] data_ord;
  logic                 pass;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= LEN_W'(1);
      signed_keys_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_LENGTH: table_length_r <= cfg_wdata[LEN_W-1:0];
        CFG_SIGNED_KEYS:  signed_keys_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Length in use, with zero taken as one and overlong taken as the depth.
  always_comb begin
    if (table_length_r == '0) begin
      n_clamp = LEN_W'(1);
    end else if (table_length_r > LEN_W'(TABLE_DEPTH)) begin
      n_clamp = LEN_W'(TABLE_DEPTH);
    end else begin
      n_clamp = table_length_r;
    end
  end

  // Judge the probe whose entry is on the read data, and pick the next midpoint.
  always_comb begin
    data_ord = order_key(rd_data_r, signed_keys_r);
    pass     = ((key_r >= data_ord) == asc_r);
    low_nxt  = pass ? mid_r : low_r;
    up_nxt   = pass ? up_r : mid_r;
    sum_cur  = {1'b0, up_r} + {1'b0, low_r};
    sum_nxt  = {1'b0, up_nxt} + {1'b0, low_nxt};
    mid_cur  = sum_cur[LEN_W:1];
    mid_nxt  = sum_nxt[LEN_W:1];
    stat.search_done = ((up_nxt - low_nxt) <= LEN_W'(1));
  end

  // Read address for each step of the query.
  always_comb begin
    priority if (cmd.capture_first) begin
      rd_addr = ADDR_W'(n_r - LEN_W'(1));
    end else if (cmd.set_dir) begin
      rd_addr = ADDR_W'(mid_cur - LEN_W'(1));
    end else if (cmd.probe) begin
      rd_addr = ADDR_W'(mid_nxt - LEN_W'(1));
    end else begin
      rd_addr = '0;
    end
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[entry_index] <= key;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Search bounds and direction.
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      key_r <= order_key(key, signed_keys_r);
      n_r   <= n_clamp;
      low_r <= '0;
      up_r  <= n_clamp + LEN_W'(1);
    end
    if (cmd.capture_first) begin
      first_r <= order_key(rd_data_r, signed_keys_r);
    end
    if (cmd.set_dir) begin
      asc_r <= (data_ord >= first_r);
      mid_r <= mid_cur;
    end
    if (cmd.probe) begin
      low_r <= low_nxt;
      up_r  <= up_nxt;
      mid_r <= mid_nxt;
    end
  end

  // Result register: the location is the last passing position minus one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.probe && stat.search_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe && stat.search_done) begin
      out_location_r <= LOC_W'(low_nxt - LEN_W'(1));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_location = out_location_r;

endmodule
`default_nettype wire

### rtl/core/monotonic_table_bracket_search_top.sv
// Top level of the monotonic table bracket search: controller plus datapath.
`default_nettype none
// A load request (in_req_type 0) writes one table entry; busy stays low.
// A query request runs a binary search over the first table_length entries:
// busy is high from the accept through the last-entry read, the direction
// step and P probes, with P at most ceil(log2(n + 1)) and n the clamped
// length. The result strobe out_valid is high in the first cycle in which
// busy is low again. The query steps follow from the single table read port:
// two reads fetch the first and last entries to find the direction, then one
// probe is judged per cycle from registered read data. The result is shown
// for exactly one cycle and cannot be held off, so the receiver must take it
// when it appears. The table is not cleared at reset; queries must only touch
// entries that were loaded.
// Configuration writes must only be made while the block is idle.
module monotonic_table_bracket_search_top
  import mtbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_req_type,
  input  wire logic [ADDR_W-1:0]     in_entry_index,
  input  wire logic [KEY_WIDTH-1:0]  in_key,
  output logic                       out_valid,
  output logic signed [LOC_W-1:0]    out_location,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t             cmd;
  stat_t            stat;
  logic [LOC_W-1:0] location;

  // Sequencer.
  mtbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Table, configuration and search arithmetic.
  mtbs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .entry_index  (in_entry_index),
    .key          (in_key),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_location (location)
  );

  assign out_location = $signed(location);

endmodule
`default_nettype wire
